>>> rtl/gfpm_pkg.sv
// gfpm_pkg: constants, register codes, stage types and stage functions of the
// GF(2^n) power map pipeline. Depends on nothing; used by gf2n_power_map_top.
package gfpm_pkg;

    // field size limit and fixed port widths
    localparam int MAX_DEGREE = 16;
    localparam int DEG_W      = $clog2(MAX_DEGREE + 1);
    localparam int IDX_W      = $clog2(MAX_DEGREE);
    localparam int ELEM_W     = 16;
    localparam int FDEG_W     = 5;
    localparam int POLY_W     = 17;
    localparam int EXP_W      = 32;
    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 2;

    // exponent reduction: bits consumed per stage and number of stages
    localparam int DIV_STEPS  = 4;
    localparam int DIV_STAGES = EXP_W / DIV_STEPS;

    // square-and-multiply: one iteration per exponent bit, two half stages each
    localparam int ITERS      = MAX_DEGREE;
    localparam int MUL_HALF   = (MAX_DEGREE + 1) / 2;

    // reset values of the registers
    localparam logic [FDEG_W-1:0] FDEG_RST = FDEG_W'(8);
    localparam logic [POLY_W-1:0] POLY_RST = POLY_W'(283);
    localparam logic [EXP_W-1:0]  EXP_RST  = EXP_W'(1);

    // register index codes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FIELD_DEGREE   = 2'd0,
        REG_REDUCTION_POLY = 2'd1,
        REG_EXPONENT       = 2'd2
    } cfg_reg_t;

    typedef logic [MAX_DEGREE-1:0] felem_t;

    // remainder stage of the exponent reduction
    typedef struct packed {
        logic [EXP_W-1:0] mag;
        felem_t           rem;
        felem_t           x;
        logic             neg;
    } div_stage_t;

    // partial shift-and-add product
    typedef struct packed {
        felem_t acc;
        felem_t x;
        felem_t y;
    } mul_state_t;

    // between square-and-multiply iterations
    typedef struct packed {
        felem_t result;
        felem_t base;
        felem_t e;
        logic   zero;
    } iter_stage_t;

    // half way through one iteration
    typedef struct packed {
        felem_t     result;
        felem_t     e;
        logic       zero;
        mul_state_t m;
        mul_state_t s;
    } mid_stage_t;

    // restoring remainder over DIV_STEPS exponent bits
    function automatic div_stage_t div_steps(div_stage_t d_in, felem_t divisor);
        div_stage_t                d;
        logic [MAX_DEGREE:0]       wide;
        d = d_in;
        for (int j = 0; j < DIV_STEPS; j++)
        begin
            wide  = {d.rem, d.mag[EXP_W-1]};
            d.mag = d.mag << 1;
            if (wide >= {1'b0, divisor})
            begin
                wide = wide - {1'b0, divisor};
            end
            d.rem = wide[MAX_DEGREE-1:0];
        end
        return d;
    endfunction

    // fresh product state for a * b
    function automatic mul_state_t mul_init(felem_t a, felem_t b);
        mul_state_t s;
        s.acc = '0;
        s.x   = a;
        s.y   = b;
        return s;
    endfunction

    // MUL_HALF shift-and-add steps starting at step first; steps at or past n idle
    function automatic mul_state_t gf_half(mul_state_t s_in, logic [DEG_W-1:0] first,
                                           logic [DEG_W-1:0] n, felem_t poly_m,
                                           felem_t mask);
        mul_state_t        s;
        logic              top;
        logic [IDX_W-1:0]  top_idx;
        logic [DEG_W:0]    step;
        s       = s_in;
        top_idx = IDX_W'(n - DEG_W'(1));
        for (int j = 0; j < MUL_HALF; j++)
        begin
            step = {1'b0, first} + (DEG_W + 1)'(j);
            if (step < {1'b0, n})
            begin
                if (s.y[0])
                begin
                    s.acc = s.acc ^ s.x;
                end
                s.y = s.y >> 1;
                top = s.x[top_idx];
                s.x = (s.x << 1) & mask;
                if (top)
                begin
                    s.x = s.x ^ poly_m;
                end
            end
        end
        return s;
    endfunction

endpackage

>>> rtl/gf2n_power_map_top.sv
// gf2n_power_map_top: streaming power map y = x^e over GF(2^n), fully pipelined.
// Depends on gfpm_pkg for constants, stage types and the stage functions.
//
//   channel   handshake            payload          width
//   input     start / busy         element          16
//   result    done (strobe)        power            16
//   config    cfg_we               cfg_index, cfg_data  2, 32
//
// One beat enters per cycle; busy stays low. Each beat passes through, in order,
// 8 remainder stages (4 exponent bits each), one fix-up stage, 16
// square-and-multiply iterations of two half-multiplier stages, and the output
// register. Reset clears every valid bit and loads the register defaults. The
// receiver cannot stall, so the pipeline never holds.
module gf2n_power_map_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [gfpm_pkg::ELEM_W-1:0]     element,
    output logic                            done,
    output logic [gfpm_pkg::ELEM_W-1:0]     power,
    input  logic                            cfg_we,
    input  logic [gfpm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gfpm_pkg::CFG_W-1:0]      cfg_data
);
    import gfpm_pkg::*;

    // configuration registers
    logic [FDEG_W-1:0]  field_degree_reg;
    logic [POLY_W-1:0]  reduction_poly_reg;
    logic [EXP_W-1:0]   exponent_reg;

    // derived field parameters
    logic [DEG_W-1:0]   n_eff;
    felem_t             mask;
    felem_t             poly_m;
    logic [MAX_DEGREE:0] mask_wide;
    logic [EXP_W-1:0]   exp_mag;
    felem_t             element_m;
    logic               accept;

    // pipeline registers
    div_stage_t         div_reg   [DIV_STAGES];
    div_stage_t         div_next  [DIV_STAGES];
    logic               div_vld_reg [DIV_STAGES];
    iter_stage_t        iter_reg  [ITERS+1];
    iter_stage_t        iter_next [ITERS+1];
    logic               iter_vld_reg [ITERS+1];
    mid_stage_t         mid_reg   [ITERS];
    mid_stage_t         mid_next  [ITERS];
    logic               mid_vld_reg [ITERS];
    mul_state_t         mul_fin   [ITERS];
    mul_state_t         sq_fin    [ITERS];
    iter_stage_t        fix_next;
    div_stage_t         div_init;
    felem_t             power_reg;
    felem_t             power_next;
    logic               done_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_degree_reg   <= FDEG_RST;
            reduction_poly_reg <= POLY_RST;
            exponent_reg       <= EXP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_FIELD_DEGREE:   field_degree_reg   <= cfg_data[FDEG_W-1:0];
                REG_REDUCTION_POLY: reduction_poly_reg <= cfg_data[POLY_W-1:0];
                REG_EXPONENT:       exponent_reg       <= cfg_data[EXP_W-1:0];
                default:            ;
            endcase
        end
    end

    // effective degree, element mask and reduction term
    always_comb
    begin
        if (field_degree_reg == '0)
        begin
            n_eff = DEG_W'(1);
        end
        else if (field_degree_reg > FDEG_W'(MAX_DEGREE))
        begin
            n_eff = DEG_W'(MAX_DEGREE);
        end
        else
        begin
            n_eff = DEG_W'(field_degree_reg);
        end
        mask_wide = ((MAX_DEGREE + 1)'(1) << n_eff) - (MAX_DEGREE + 1)'(1);
        mask      = mask_wide[MAX_DEGREE-1:0];
        poly_m    = MAX_DEGREE'(reduction_poly_reg) & mask;
        element_m = MAX_DEGREE'(element) & mask;
        exp_mag   = exponent_reg[EXP_W-1] ? (~exponent_reg + EXP_W'(1)) : exponent_reg;
    end

    // exponent magnitude modulo 2^n-1
    always_comb
    begin
        div_init.mag = exp_mag;
        div_init.rem = '0;
        div_init.x   = element_m;
        div_init.neg = exponent_reg[EXP_W-1];
        div_next[0]  = div_steps(div_init, mask);
        for (int k = 1; k < DIV_STAGES; k++)
        begin
            div_next[k] = div_steps(div_reg[k-1], mask);
        end
    end

    // fix-up of a negative remainder and loop set-up
    always_comb
    begin
        fix_next.result = MAX_DEGREE'(1);
        fix_next.base   = div_reg[DIV_STAGES-1].x;
        fix_next.zero   = (div_reg[DIV_STAGES-1].x == '0);
        if (div_reg[DIV_STAGES-1].neg && (div_reg[DIV_STAGES-1].rem != '0))
        begin
            fix_next.e = mask - div_reg[DIV_STAGES-1].rem;
        end
        else
        begin
            fix_next.e = div_reg[DIV_STAGES-1].rem;
        end
    end

    // square-and-multiply iterations, each split over two half multipliers
    always_comb
    begin
        iter_next[0] = fix_next;
        for (int i = 0; i < ITERS; i++)
        begin
            mid_next[i].result = iter_reg[i].result;
            mid_next[i].e      = iter_reg[i].e;
            mid_next[i].zero   = iter_reg[i].zero;
            mid_next[i].m      = gf_half(mul_init(iter_reg[i].result, iter_reg[i].base),
                                         DEG_W'(0), n_eff, poly_m, mask);
            mid_next[i].s      = gf_half(mul_init(iter_reg[i].base, iter_reg[i].base),
                                         DEG_W'(0), n_eff, poly_m, mask);
        end
        for (int i = 0; i < ITERS; i++)
        begin
            mul_fin[i] = gf_half(mid_reg[i].m, DEG_W'(MUL_HALF), n_eff, poly_m, mask);
            sq_fin[i]  = gf_half(mid_reg[i].s, DEG_W'(MUL_HALF), n_eff, poly_m, mask);
            iter_next[i+1].result = mid_reg[i].e[0] ? mul_fin[i].acc : mid_reg[i].result;
            iter_next[i+1].base   = sq_fin[i].acc;
            iter_next[i+1].e      = mid_reg[i].e >> 1;
            iter_next[i+1].zero   = mid_reg[i].zero;
        end
        power_next = iter_reg[ITERS].zero ? '0 : iter_reg[ITERS].result;
    end

    // valid bits travel with the beats
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                div_vld_reg[k] <= 1'b0;
            end
            for (int i = 0; i <= ITERS; i++)
            begin
                iter_vld_reg[i] <= 1'b0;
            end
            for (int i = 0; i < ITERS; i++)
            begin
                mid_vld_reg[i] <= 1'b0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            div_vld_reg[0] <= accept;
            for (int k = 1; k < DIV_STAGES; k++)
            begin
                div_vld_reg[k] <= div_vld_reg[k-1];
            end
            iter_vld_reg[0] <= div_vld_reg[DIV_STAGES-1];
            for (int i = 0; i < ITERS; i++)
            begin
                mid_vld_reg[i]    <= iter_vld_reg[i];
                iter_vld_reg[i+1] <= mid_vld_reg[i];
            end
            done_reg <= iter_vld_reg[ITERS];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            div_reg[k] <= div_next[k];
        end
        for (int i = 0; i <= ITERS; i++)
        begin
            iter_reg[i] <= iter_next[i];
        end
        for (int i = 0; i < ITERS; i++)
        begin
            mid_reg[i] <= mid_next[i];
        end
        power_reg <= power_next;
    end

    assign done  = done_reg;
    assign power = ELEM_W'(power_reg);

endmodule
